// ===== design/pcfa_pkg.sv =====
// Shared constants and types for the particle contact force accumulator.
`timescale 1ns / 1ps

package pcfa_pkg;

	// serial multiplier: A operand width, B operand width (one B bit per cycle)
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 34;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	// serial restoring divider: one quotient bit per cycle
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 34;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	// serial square root: two radicand bits per cycle
	localparam int SQRT_X_W = 64;
	localparam int SQRT_R_W = SQRT_X_W / 2;
	localparam int SQRT_REM_W = SQRT_R_W + 2;
	localparam int SQRT_CNT_W = $clog2(SQRT_R_W);

	localparam int SUM_W = 48;

	// configuration register indexes
	localparam logic [1:0] REG_FORCE_SCALE = 2'd0;
	localparam logic [1:0] REG_CONTACT_SCALE = 2'd1;
	localparam logic [1:0] REG_BOND_SCALE = 2'd2;
	localparam logic [1:0] REG_DIMENSIONS = 2'd3;

	localparam logic [31:0] FORCE_SCALE_RST = 32'd196608;
	localparam logic [16:0] CONTACT_SCALE_RST = 17'd58982;
	localparam logic [16:0] BOND_SCALE_RST = 17'd45875;
	localparam logic [1:0] DIMENSIONS_RST = 2'd3;

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [SUM_W-1:0] K_CAP = {SUM_W{1'b1}};

	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;

endpackage

// ===== design/pcfa_mul.sv =====
// Bit-serial shift-add multiplier, one bit of B per cycle.
`timescale 1ns / 1ps

module pcfa_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pcfa_pkg::MUL_A_W-1:0] a,
	input  logic [pcfa_pkg::MUL_B_W-1:0] b,
	output logic                         done,
	output logic [pcfa_pkg::MUL_P_W-1:0] p
);

	logic                           busy_q;
	logic                           done_q;
	logic [pcfa_pkg::MUL_CNT_W-1:0] cnt_q;
	logic [pcfa_pkg::MUL_A_W-1:0]   a_q;
	logic [pcfa_pkg::MUL_A_W-1:0]   hi_q;
	logic [pcfa_pkg::MUL_B_W-1:0]   lo_q;
	logic [pcfa_pkg::MUL_A_W:0]     part;

	assign part = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= pcfa_pkg::MUL_CNT_W'(pcfa_pkg::MUL_B_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= part[pcfa_pkg::MUL_A_W:1];
			lo_q <= {part[0], lo_q[pcfa_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign p = {hi_q, lo_q};

endmodule

// ===== design/pcfa_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pcfa_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pcfa_pkg::DIV_N_W-1:0] n,
	input  logic [pcfa_pkg::DIV_D_W-1:0] d,
	output logic                         done,
	output logic [pcfa_pkg::DIV_N_W-1:0] q
);

	logic                           busy_q;
	logic                           done_q;
	logic [pcfa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [pcfa_pkg::DIV_N_W-1:0]   n_q;
	logic [pcfa_pkg::DIV_D_W-1:0]   d_q;
	logic [pcfa_pkg::DIV_D_W-1:0]   rem_q;
	logic [pcfa_pkg::DIV_D_W:0]     trial;
	logic [pcfa_pkg::DIV_D_W:0]     diff;
	logic                           ge;

	assign trial = {rem_q, n_q[pcfa_pkg::DIV_N_W-1]};
	assign diff = trial - {1'b0, d_q};
	assign ge = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= pcfa_pkg::DIV_CNT_W'(pcfa_pkg::DIV_N_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits back in DIV_D_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			d_q <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[pcfa_pkg::DIV_D_W-1:0] : trial[pcfa_pkg::DIV_D_W-1:0];
			n_q <= {n_q[pcfa_pkg::DIV_N_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign q = n_q;

endmodule

// ===== design/pcfa_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module pcfa_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pcfa_pkg::SQRT_X_W-1:0] x,
	output logic                          done,
	output logic [pcfa_pkg::SQRT_R_W-1:0] root
);

	logic                            busy_q;
	logic                            done_q;
	logic [pcfa_pkg::SQRT_CNT_W-1:0] cnt_q;
	logic [pcfa_pkg::SQRT_X_W-1:0]   x_q;
	logic [pcfa_pkg::SQRT_R_W-1:0]   root_q;
	logic [pcfa_pkg::SQRT_REM_W-1:0] rem_q;
	logic [pcfa_pkg::SQRT_REM_W+1:0] cur;
	logic [pcfa_pkg::SQRT_REM_W+1:0] trial;
	logic [pcfa_pkg::SQRT_REM_W+1:0] diff;
	logic                            ge;

	assign cur = {rem_q, x_q[pcfa_pkg::SQRT_X_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff = cur - trial;
	assign ge = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= pcfa_pkg::SQRT_CNT_W'(pcfa_pkg::SQRT_R_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// partial remainder never exceeds twice the partial root
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			root_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[pcfa_pkg::SQRT_REM_W-1:0] : cur[pcfa_pkg::SQRT_REM_W-1:0];
			root_q <= {root_q[pcfa_pkg::SQRT_R_W-2:0], ge};
			x_q <= {x_q[pcfa_pkg::SQRT_X_W-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== design/particle_contact_force_accumulator_core.sv =====
// Top level: neighbour sequencer, contact test and force accumulation.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready  | tdata 288b, tuser 2b, tlast = last_neighbour
//  m_axis   | m_axis_tvalid/m_axis_tready  | tdata 144b, tuser 2b
//  cfg      | cfg_valid/cfg_ready          | cfg_index 2b, cfg_data 32b
//
// One word at a time: a new neighbour is taken only when the previous one is finished.
// An intact bond goes from the accept straight to the finish state; a full contact runs
// 13 serial products (34-bit multiplier operand, one bit a cycle), 5 quotients
// (64-bit dividend) and one square root between the accept and finish states.
// Reset clears sums and flags and sets the configuration registers to their defaults; cfg_ready is always high.
// A pending result in the output register stalls only the next last neighbour.
`timescale 1ns / 1ps

module particle_contact_force_accumulator_core (
	input  logic         clk,
	input  logic         arst_n,
	// tdata: delta_x, delta_y, delta_z, radius_self, radius_other, modulus_self,
	//        modulus_other, volume_other, initial_length (32b each, lowest first)
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [287:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,   // [0] was_bonded, [1] bond_intact
	input  logic         s_axis_tlast,
	// tdata: force_x, force_y, force_z (48b each, lowest first)
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // [0] any_contact, [1] zero_gap_seen
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int AW = pcfa_pkg::MUL_A_W;
	localparam int BW = pcfa_pkg::MUL_B_W;
	localparam int SW = pcfa_pkg::SUM_W;

	typedef enum logic [14:0] {
		ST_IDLE = 15'b000000000000001,
		ST_SQ   = 15'b000000000000010,
		ST_RS2  = 15'b000000000000100,
		ST_DIV5 = 15'b000000000001000,
		ST_CDA  = 15'b000000000010000,
		ST_CDB  = 15'b000000000100000,
		ST_CD2  = 15'b000000001000000,
		ST_SQRT = 15'b000000010000000,
		ST_DS   = 15'b000000100000000,
		ST_K1   = 15'b000001000000000,
		ST_K2   = 15'b000010000000000,
		ST_K3   = 15'b000100000000000,
		ST_UDIV = 15'b001000000000000,
		ST_FMUL = 15'b010000000000000,
		ST_FIN  = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] force_scale_q;
	logic [16:0] contact_scale_q;
	logic [16:0] bond_scale_q;
	logic [1:0]  dims_q;

	// captured neighbour
	logic [31:0] mag_q [3];
	logic [2:0]  neg_q;
	logic [32:0] rsum_q;
	logic [31:0] cmod_q;
	logic [31:0] vol_q;
	logic [31:0] ilen_q;
	logic        bonded_q;
	logic        last_q;

	// working values
	logic [1:0]    comp_q;
	logic          pend_q;
	logic [63:0]   dist2_q;
	logic [63:0]   s_q;
	logic [33:0]   a_q;
	logic [33:0]   cd_q;
	logic [31:0]   len_q;
	logic [16:0]   ds_q;
	logic [SW-1:0] k_q;
	logic [16:0]   u_q;

	// accumulators and result register
	logic [SW-1:0] sum_x_q;
	logic [SW-1:0] sum_y_q;
	logic [SW-1:0] sum_z_q;
	logic          contact_q;
	logic          zero_gap_q;
	logic          m_valid_q;
	logic [143:0]  m_data_q;
	logic [1:0]    m_user_q;

	// units
	pcfa_pkg::unit_ctl_t        mul_ctl;
	pcfa_pkg::unit_ctl_t        div_ctl;
	pcfa_pkg::unit_ctl_t        sqrt_ctl;
	logic [AW-1:0]              mul_a;
	logic [BW-1:0]              mul_b;
	logic [pcfa_pkg::MUL_P_W-1:0] mul_p;
	logic [pcfa_pkg::DIV_N_W-1:0] div_n;
	logic [pcfa_pkg::DIV_D_W-1:0] div_d;
	logic [pcfa_pkg::DIV_N_W-1:0] div_q;
	logic [31:0]                sqrt_root;

	logic          accept;
	logic [1:0]    dims_eff;
	logic [31:0]   in_mag [3];
	logic [2:0]    in_neg;
	logic [32:0]   in_rsum;
	logic [32:0]   in_msum;
	logic [65:0]   pre_thr;
	logic          pre_ok;
	logic [33:0]   cd_b;
	logic [33:0]   cd_min;
	logic [33:0]   cd_gap;
	logic [SW-1:0] k_vol;
	logic [SW-1:0] f_mag;
	logic [SW-1:0] sum_cur;
	logic [SW+1:0] sum_ext;
	logic [SW+1:0] sum_t;
	logic [SW-1:0] sum_new;
	logic          out_free;
	logic          out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_FIN) && last_q && out_free;

	assign dims_eff = (dims_q == 2'd0) ? 2'd1 : dims_q;
	assign in_rsum = {1'b0, s_axis_tdata[127:96]} + {1'b0, s_axis_tdata[159:128]};
	assign in_msum = {1'b0, s_axis_tdata[191:160]} + {1'b0, s_axis_tdata[223:192]};

	always_comb begin
		logic [31:0] dv;
		for (int i = 0; i < 3; i++) begin
			dv = s_axis_tdata[32*i +: 32];
			if (2'(i) < dims_eff) begin
				in_mag[i] = dv[31] ? (32'd0 - dv) : dv;
				in_neg[i] = dv[31];
			end else begin
				in_mag[i] = '0;
				in_neg[i] = 1'b0;
			end
		end
	end

	// dist2 < 1.8 * rsum^2 as dist2 < 2s - floor(s/5)
	assign pre_thr = {1'b0, s_q, 1'b0} - {2'b00, div_q};
	assign pre_ok = {2'b00, dist2_q} < pre_thr;

	assign cd_b = {1'b0, mul_p[48:16]};
	assign cd_min = (a_q < cd_b) ? a_q : cd_b;
	assign cd_gap = cd_q - {2'b00, len_q};

	assign k_vol = (mul_p[pcfa_pkg::MUL_P_W-1:64] != '0) ? pcfa_pkg::K_CAP : mul_p[63:16];
	assign f_mag = mul_p[63:16];

	always_comb begin
		case (comp_q)
			2'd0: sum_cur = sum_x_q;
			2'd1: sum_cur = sum_y_q;
			default: sum_cur = sum_z_q;
		endcase
	end

	// force points away from the neighbour: add for negative delta, subtract otherwise
	assign sum_ext = {{2{sum_cur[SW-1]}}, sum_cur};
	assign sum_t = neg_q[comp_q] ? (sum_ext + {2'b00, f_mag}) : (sum_ext - {2'b00, f_mag});

	always_comb begin
		if (sum_t[SW+1:SW-1] == 3'b000 || sum_t[SW+1:SW-1] == 3'b111) begin
			sum_new = sum_t[SW-1:0];
		end else if (sum_t[SW+1]) begin
			sum_new = pcfa_pkg::SUM_MIN;
		end else begin
			sum_new = pcfa_pkg::SUM_MAX;
		end
	end

	// operand selection for the shared units
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = '0;
		unique case (state_q)
			ST_SQ: begin
				mul_a = AW'(mag_q[comp_q]);
				mul_b = BW'(mag_q[comp_q]);
			end
			ST_RS2: begin
				mul_a = AW'(rsum_q);
				mul_b = BW'(rsum_q);
			end
			ST_CDA: begin
				mul_a = AW'(rsum_q);
				mul_b = BW'(contact_scale_q);
			end
			ST_CDB: begin
				mul_a = AW'(ilen_q);
				mul_b = BW'(bond_scale_q);
			end
			ST_CD2: begin
				mul_a = AW'(cd_q);
				mul_b = cd_q;
			end
			ST_K1: begin
				mul_a = AW'(force_scale_q);
				mul_b = BW'(cmod_q);
			end
			ST_K2: begin
				mul_a = k_q;
				mul_b = BW'(ds_q);
			end
			ST_K3: begin
				mul_a = k_q;
				mul_b = BW'(vol_q);
			end
			ST_FMUL: begin
				mul_a = k_q;
				mul_b = BW'(u_q);
			end
			ST_DIV5: begin
				div_n = s_q;
				div_d = pcfa_pkg::DIV_D_W'(5);
			end
			ST_DS: begin
				div_n = {14'd0, cd_gap, 16'd0};
				div_d = cd_q;
			end
			ST_UDIV: begin
				div_n = {16'd0, mag_q[comp_q], 16'd0};
				div_d = pcfa_pkg::DIV_D_W'(len_q);
			end
			ST_IDLE, ST_SQRT, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mul_ctl.start = !pend_q && (
			(state_q == ST_SQ) ||
			(state_q == ST_RS2 && !rsum_q[32]) ||
			(state_q == ST_CDA && bonded_q) ||
			(state_q == ST_CDB) ||
			(state_q == ST_CD2 && cd_q[33:32] == 2'b00) ||
			(state_q == ST_K1) ||
			(state_q == ST_K2 && !ds_q[16]) ||
			(state_q == ST_K3) ||
			(state_q == ST_FMUL));
		div_ctl.start = !pend_q &&
			(state_q == ST_DIV5 || state_q == ST_DS || state_q == ST_UDIV);
		sqrt_ctl.start = !pend_q && (state_q == ST_SQRT);
	end

	pcfa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_ctl.start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_ctl.done),
		.p      (mul_p)
	);

	pcfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_ctl.start),
		.n      (div_n),
		.d      (div_d),
		.done   (div_ctl.done),
		.q      (div_q)
	);

	pcfa_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_ctl.start),
		.x      (dist2_q),
		.done   (sqrt_ctl.done),
		.root   (sqrt_root)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_scale_q <= pcfa_pkg::FORCE_SCALE_RST;
			contact_scale_q <= pcfa_pkg::CONTACT_SCALE_RST;
			bond_scale_q <= pcfa_pkg::BOND_SCALE_RST;
			dims_q <= pcfa_pkg::DIMENSIONS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcfa_pkg::REG_FORCE_SCALE: force_scale_q <= cfg_data;
				pcfa_pkg::REG_CONTACT_SCALE: contact_scale_q <= cfg_data[16:0];
				pcfa_pkg::REG_BOND_SCALE: bond_scale_q <= cfg_data[16:0];
				pcfa_pkg::REG_DIMENSIONS: dims_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// neighbour capture
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= in_mag[i];
			end
			neg_q <= in_neg;
			rsum_q <= in_rsum;
			cmod_q <= in_msum[32:1];
			vol_q <= s_axis_tdata[255:224];
			ilen_q <= s_axis_tdata[287:256];
			bonded_q <= s_axis_tuser[0];
			last_q <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= (pend_q | mul_ctl.start | div_ctl.start | sqrt_ctl.start) &
				~(mul_ctl.done | div_ctl.done | sqrt_ctl.done);
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			comp_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			contact_q <= 1'b0;
			zero_gap_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						comp_q <= '0;
						dist2_q <= '0;
						state_q <= (s_axis_tuser[0] && s_axis_tuser[1]) ? ST_FIN : ST_SQ;
					end
				end
				ST_SQ: begin
					if (mul_ctl.done) begin
						dist2_q <= dist2_q + mul_p[63:0];
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							state_q <= ST_RS2;
						end else begin
							comp_q <= comp_q + 1'b1;
						end
					end
				end
				ST_RS2: begin
					if (rsum_q[32]) begin
						state_q <= ST_CDA;
					end else if (mul_ctl.done) begin
						s_q <= mul_p[63:0];
						state_q <= ST_DIV5;
					end
				end
				ST_DIV5: begin
					if (div_ctl.done) begin
						state_q <= pre_ok ? ST_CDA : ST_FIN;
					end
				end
				ST_CDA: begin
					if (!bonded_q) begin
						cd_q <= {1'b0, rsum_q};
						state_q <= ST_CD2;
					end else if (mul_ctl.done) begin
						a_q <= mul_p[49:16];
						state_q <= ST_CDB;
					end
				end
				ST_CDB: begin
					if (mul_ctl.done) begin
						cd_q <= cd_min;
						state_q <= ST_CD2;
					end
				end
				ST_CD2: begin
					if (cd_q[33:32] != 2'b00) begin
						state_q <= ST_SQRT;
					end else if (mul_ctl.done) begin
						state_q <= (dist2_q <= mul_p[63:0]) ? ST_SQRT : ST_FIN;
					end
				end
				ST_SQRT: begin
					if (sqrt_ctl.done) begin
						len_q <= sqrt_root;
						if (sqrt_root == '0) begin
							zero_gap_q <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_DS;
						end
					end
				end
				ST_DS: begin
					if (div_ctl.done) begin
						ds_q <= div_q[16:0];
						state_q <= ST_K1;
					end
				end
				ST_K1: begin
					if (mul_ctl.done) begin
						k_q <= mul_p[63:16];
						state_q <= ST_K2;
					end
				end
				ST_K2: begin
					if (ds_q[16]) begin
						state_q <= ST_K3;
					end else if (mul_ctl.done) begin
						k_q <= mul_p[63:16];
						state_q <= ST_K3;
					end
				end
				ST_K3: begin
					if (mul_ctl.done) begin
						k_q <= k_vol;
						comp_q <= '0;
						state_q <= ST_UDIV;
					end
				end
				ST_UDIV: begin
					if (div_ctl.done) begin
						u_q <= div_q[16:0];
						state_q <= ST_FMUL;
					end
				end
				ST_FMUL: begin
					if (mul_ctl.done) begin
						case (comp_q)
							2'd0: sum_x_q <= sum_new;
							2'd1: sum_y_q <= sum_new;
							default: sum_z_q <= sum_new;
						endcase
						if (comp_q == 2'd2) begin
							contact_q <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							comp_q <= comp_q + 1'b1;
							state_q <= ST_UDIV;
						end
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_data_q <= {sum_z_q, sum_y_q, sum_x_q};
						m_user_q <= {zero_gap_q, contact_q};
						sum_x_q <= '0;
						sum_y_q <= '0;
						sum_z_q <= '0;
						contact_q <= 1'b0;
						zero_gap_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the particle contact force accumulator core: directed, register, back-pressure and random tests.
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		logic signed [31:0] dx, dy, dz;
		logic [31:0] r_self, r_other, m_self, m_other, vol, init_len;
		logic bonded, intact, last;
	} neighbour_t;

	typedef struct {
		logic [47:0] fx, fy, fz;
		logic contact, zero_gap;
	} force_sum_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
	logic [287:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid, m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	particle_contact_force_accumulator_core i_dut (.*);

	// mirrored registers and accumulator state
	logic [31:0] p_force_scale;
	logic [16:0] p_contact_scale, p_bond_scale;
	logic [1:0] p_dims;
	logic signed [63:0] acc_x, acc_y, acc_z;
	logic acc_contact, acc_zero;

	force_sum_t expected_sums[$];
	int mismatches, sums_checked, contacts_seen, zero_gaps_seen, neighbours_sent;
	bit idle_on, hold_req;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#200_000_000;
		$display("particle_contact_force_accumulator_core test failed");
		$finish;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sat48(logic signed [63:0] v);
		if (v > 64'sd140737488355327) return 64'sd140737488355327;
		if (v < -64'sd140737488355328) return -64'sd140737488355328;
		return v;
	endfunction

	// applies one neighbour to the mirrored sums; returns 1 with the sums on the last one
	function automatic bit accumulate_neighbour(neighbour_t n, output force_sum_t res);
		logic signed [63:0] d[3];
		logic [63:0] mg[3];
		logic [63:0] dist2, rsum, cd, a, b, len, s, ds, c;
		logic [127:0] k, u;
		int dims;
		dims = (p_dims == 0) ? 1 : p_dims;
		d[0] = n.dx;
		d[1] = (dims > 1) ? 64'(n.dy) : 0;
		d[2] = (dims > 2) ? 64'(n.dz) : 0;
		dist2 = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = d[i] < 0 ? -d[i] : d[i];
			dist2 += mg[i] * mg[i];
		end
		rsum = 64'(n.r_self) + 64'(n.r_other);
		s = rsum * rsum;
		if ((rsum >= 64'h1_0000_0000 || dist2 < s || dist2 - s < s - s / 5)
				&& !(n.bonded && n.intact)) begin
			cd = rsum;
			if (n.bonded) begin
				a = (rsum * p_contact_scale) >> 16;
				b = (64'(n.init_len) * p_bond_scale) >> 16;
				cd = a < b ? a : b;
			end
			if (cd >= 64'h1_0000_0000 || dist2 <= cd * cd) begin
				len = floor_sqrt(dist2);
				if (len == 0) begin
					acc_zero = 1'b1;
				end else begin
					c = (64'(n.m_self) + 64'(n.m_other)) >> 1;
					ds = ((cd - len) << 16) / cd;
					k = (128'(p_force_scale) * c) >> 16;
					if (ds < 65536) k = (k * ds) >> 16;
					k = (k * n.vol) >> 16;
					if (k > 128'(pcfa_pkg::K_CAP)) k = 128'(pcfa_pkg::K_CAP);
					for (int i = 0; i < 3; i++) begin
						u = (128'(mg[i]) << 16) / len;
						u = (k * u) >> 16;
						if (d[i] != 0) begin
							if (i == 0) acc_x = sat48(d[i] > 0 ? acc_x - 64'(u) : acc_x + 64'(u));
							if (i == 1) acc_y = sat48(d[i] > 0 ? acc_y - 64'(u) : acc_y + 64'(u));
							if (i == 2) acc_z = sat48(d[i] > 0 ? acc_z - 64'(u) : acc_z + 64'(u));
						end
					end
					acc_contact = 1'b1;
				end
			end
		end
		if (!n.last) return 0;
		res.fx = acc_x[47:0];
		res.fy = acc_y[47:0];
		res.fz = acc_z[47:0];
		res.contact = acc_contact;
		res.zero_gap = acc_zero;
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		acc_contact = 1'b0;
		acc_zero = 1'b0;
		return 1;
	endfunction

	task automatic send_neighbour(neighbour_t n);
		int gap;
		force_sum_t res;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {n.init_len, n.vol, n.m_other, n.m_self, n.r_other, n.r_self,
			n.dz, n.dy, n.dx};
		s_axis_tuser <= {n.intact, n.bonded};
		s_axis_tlast <= n.last;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		neighbours_sent++;
		if (accumulate_neighbour(n, res)) expected_sums.push_back(res);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			pcfa_pkg::REG_FORCE_SCALE: p_force_scale = val;
			pcfa_pkg::REG_CONTACT_SCALE: p_contact_scale = val[16:0];
			pcfa_pkg::REG_BOND_SCALE: p_bond_scale = val[16:0];
			pcfa_pkg::REG_DIMENSIONS: p_dims = val[1:0];
		endcase
	endtask

	// wait for every sum, then let a trailing neighbour finish
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (900) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_delta(logic [63:0] lim);
		logic [31:0] m;
		if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
		m = $urandom_range(0, lim[31:0]);
		return $urandom_range(0, 1) ? -$signed(m) : $signed(m);
	endfunction

	function automatic neighbour_t random_neighbour();
		neighbour_t n;
		int mode, sh;
		logic [63:0] rs;
		sh = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(8, 24);
		n.r_self = $urandom >> sh;
		n.r_other = $urandom >> sh;
		n.m_self = $urandom >> $urandom_range(0, 31);
		n.m_other = $urandom >> $urandom_range(0, 31);
		n.vol = $urandom >> $urandom_range(0, 31);
		rs = 64'(n.r_self) + 64'(n.r_other);
		n.init_len = rs[31:0] + $urandom_range(0, 4096) - 2048;
		n.bonded = $urandom_range(0, 2) == 0;
		n.intact = $urandom_range(0, 1) == 1;
		n.last = $urandom_range(0, 3) == 0;
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			// within reach: spread the gap over the components
			n.dx = rand_delta(rs / 2);
			n.dy = rand_delta(rs / 2);
			n.dz = rand_delta(rs / 2);
		end else if (mode == 6) begin
			n.dx = 0;
			n.dy = 0;
			n.dz = 0;
		end else begin
			n.dx = $urandom;
			n.dy = $urandom;
			n.dz = $urandom;
			n.init_len = $urandom;
		end
		return n;
	endfunction

	function automatic neighbour_t make_nb(logic signed [31:0] dx, dy, dz, logic [31:0] r,
			logic b, i, l);
		neighbour_t n;
		n.dx = dx; n.dy = dy; n.dz = dz;
		n.r_self = r; n.r_other = r;
		n.m_self = 32'h0001_0000; n.m_other = 32'h0003_0000;
		n.vol = 32'h0000_8000; n.init_len = 2 * r;
		n.bonded = b; n.intact = i; n.last = l;
		return n;
	endfunction

	task automatic test_directed();
		neighbour_t n;
		idle_on = 1'b0;
		send_neighbour(make_nb(32'sh1_0000, 0, 0, 32'h1_0000, 1'b0, 1'b0, 1'b1));
		send_neighbour(make_nb(-32'sh1_0000, 32'sh8000, -32'sh4000, 32'h1_0000,
			1'b0, 1'b0, 1'b0));
		send_neighbour(make_nb(0, 0, 0, 32'h1_0000, 1'b0, 1'b0, 1'b1));        // coincident
		send_neighbour(make_nb(32'sh1000, 0, 0, 32'h1_0000, 1'b1, 1'b1, 1'b1)); // intact bond
		send_neighbour(make_nb(32'sh1000, 0, 0, 32'h1_0000, 1'b0, 1'b1, 1'b0)); // flag alone
		send_neighbour(make_nb(32'sh1000, 0, 0, 32'h1_0000, 1'b1, 1'b0, 1'b1)); // broken bond
		send_neighbour(make_nb(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
		send_neighbour(make_nb(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
			32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1));
		send_neighbour(make_nb(32'sh10_0000, 0, 0, 32'h1000, 1'b0, 1'b0, 1'b1)); // out of range
		n = make_nb(32'sh100, -32'sh100, 32'sh100, 32'h4000_0000, 1'b0, 1'b0, 1'b0);
		n.m_self = '1; n.m_other = '1; n.vol = '1;
		repeat (4) send_neighbour(n);                                   // saturate sums
		n.dx = -n.dx; n.dy = -n.dy; n.dz = -n.dz; n.last = 1'b1;
		repeat (4) send_neighbour(n);
		n = make_nb(32'sh1000, 0, 0, 0, 1'b0, 1'b0, 1'b1);               // zero radii
		send_neighbour(n);
		drain();
	endtask

	task automatic random_block(int count);
		neighbour_t n;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) idle_on = $urandom_range(0, 3) != 0;
			n = random_neighbour();
			if (i == count - 1) n.last = 1'b1;
			send_neighbour(n);
		end
		drain();
	endtask

	task automatic test_register_settings();
		logic [31:0] fs[4] = '{32'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000};
		logic [16:0] sc[4] = '{17'd0, 17'd65536, 17'd1, 17'd30000};
		logic [1:0] dm[4] = '{2'd1, 2'd2, 2'd0, 2'd3};
		for (int p = 0; p < 4; p++) begin
			write_reg(pcfa_pkg::REG_FORCE_SCALE, fs[p]);
			write_reg(pcfa_pkg::REG_CONTACT_SCALE, 32'(sc[p]));
			write_reg(pcfa_pkg::REG_BOND_SCALE, 32'(sc[3 - p]));
			write_reg(pcfa_pkg::REG_DIMENSIONS, 32'(dm[p]));
			random_block(80);
		end
		// random register contents, then back to the defaults
		for (int p = 0; p < 3; p++) begin
			write_reg(pcfa_pkg::REG_FORCE_SCALE, $urandom);
			write_reg(pcfa_pkg::REG_CONTACT_SCALE, $urandom_range(0, 65536));
			write_reg(pcfa_pkg::REG_BOND_SCALE, $urandom_range(0, 65536));
			write_reg(pcfa_pkg::REG_DIMENSIONS, $urandom_range(1, 3));
			random_block(60);
		end
		write_reg(pcfa_pkg::REG_FORCE_SCALE, pcfa_pkg::FORCE_SCALE_RST);
		write_reg(pcfa_pkg::REG_CONTACT_SCALE, 32'(pcfa_pkg::CONTACT_SCALE_RST));
		write_reg(pcfa_pkg::REG_BOND_SCALE, 32'(pcfa_pkg::BOND_SCALE_RST));
		write_reg(pcfa_pkg::REG_DIMENSIONS, 32'(pcfa_pkg::DIMENSIONS_RST));
	endtask

	task automatic test_output_backpressure();
		neighbour_t n;
		idle_on = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++) begin
			n = random_neighbour();
			n.last = i % 3 == 2;
			send_neighbour(n);
		end
		drain();
	endtask

	// result side: random stalls, one long hold on request, checks each word
	initial begin
		int n;
		force_sum_t exp_s;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				n = 8000;
			end else begin
				n = idle_on ? $urandom_range(0, 11) : 0;
			end
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready && arst_n));
			if (expected_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected force word %h", m_axis_tdata);
			end else begin
				exp_s = expected_sums.pop_front();
				sums_checked++;
				if (exp_s.contact) contacts_seen++;
				if (exp_s.zero_gap) zero_gaps_seen++;
				if (m_axis_tdata !== {exp_s.fz, exp_s.fy, exp_s.fx}
						|| m_axis_tuser !== {exp_s.zero_gap, exp_s.contact}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sum %0d: exp x %h y %h z %h c %b z %b, got x %h y %h z %h user %b",
							sums_checked, exp_s.fx, exp_s.fy, exp_s.fz, exp_s.contact,
							exp_s.zero_gap, m_axis_tdata[47:0], m_axis_tdata[95:48],
							m_axis_tdata[143:96], m_axis_tuser);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = pcfa_pkg::REG_FORCE_SCALE;
		cfg_data = '0;
		p_force_scale = pcfa_pkg::FORCE_SCALE_RST;
		p_contact_scale = pcfa_pkg::CONTACT_SCALE_RST;
		p_bond_scale = pcfa_pkg::BOND_SCALE_RST;
		p_dims = pcfa_pkg::DIMENSIONS_RST;
		acc_x = 0; acc_y = 0; acc_z = 0;
		acc_contact = 1'b0; acc_zero = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_settings();
		test_output_backpressure();
		random_block(1350);
		if (expected_sums.size() != 0) mismatches++;
		$display("%0d neighbours sent, %0d force sums checked",
			neighbours_sent, sums_checked);
		$display("%0d sums with contact, %0d with a coincident neighbour; covered register %s",
			contacts_seen, zero_gaps_seen, "extremes, bonds, saturation and output hold-off");
		if (mismatches == 0)
			$display("particle_contact_force_accumulator_core test passed");
		else
			$display("particle_contact_force_accumulator_core test failed");
		$finish;
	end

endmodule
